FILE: hw/rtl/ipsv_pkg.sv
// Shared constants for the inverse Park / inverse Clarke / space-vector stage.
// Holds the CORDIC arctangent table and the fixed-point gain constants.
// No dependencies.
package ipsv_pkg;

   // arctangent of 2^-i in units of 2^32 per turn
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   localparam int ATAN_DEPTH = 32;

   // reciprocal CORDIC gain in Q1.30, the start value of x
   localparam logic signed [31:0] TRIG_ONE_GAIN = 32'sd652032874;

   // sqrt(3)/2 in Q1.30
   localparam logic signed [31:0] HALF_SQRT3_Q30 = 32'sd929887697;

   // half an LSB for the Q60 to Q30 rounding of the beta product
   localparam logic signed [63:0] HALF_Q30_RND = 64'sd536870912;

endpackage

FILE: hw/rtl/inverse_park_svpwm.sv
// Top level of the field-oriented voltage stage: CORDIC sine/cosine, inverse Park,
// inverse Clarke and min-max zero-sequence injection. Depends on ipsv_pkg.

// The block takes one request per clock cycle and returns one result per request, in
// order. Sine and cosine come from a pipelined CORDIC with an input register and one
// register stage per iteration, followed by ten arithmetic stages (products, sums, the
// sqrt3/2 scaling, min/max search, neutral removal, output rounding) and an output
// register. A one-entry skid buffer behind the output register takes one more result
// while a result waits; after that req_tready drops until the result side drains.
// There is no state between requests and nothing to configure.
module inverse_park_svpwm #(
   parameter int VOLTAGE_BITS  = 16,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // fields from bit 0: q_voltage, d_voltage, angle, zero fill
   input  logic [((2*VOLTAGE_BITS+ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   // result channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fields from bit 0: phase_a, phase_b, phase_c, zero fill
   output logic [((3*(VOLTAGE_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   import ipsv_pkg::*;

   localparam int VB    = VOLTAGE_BITS;
   localparam int NS    = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
   localparam int RSP_W = ((3*(VB+2)+7)/8)*8;
   localparam int OW    = VB + 2;          // output field width
   localparam int PW    = 32 + VB;         // product of Q1.30 and voltage
   localparam int SW    = PW + 1;          // sum of two products
   localparam int AW    = 33;              // alpha and beta in Q30
   localparam int PHW   = 35;              // phase values in Q30
   localparam int TW    = PHW + 1;         // output rounding
   localparam int OSH   = 31 - VB;         // Q30 to Q(VB-1) shift
   localparam int OSHP  = (OSH > 0) ? OSH : 1;

   localparam logic signed [SW-1:0] RND_V = SW'(1) <<< (VB-2);
   localparam logic signed [TW-1:0] RND_O = TW'(1) <<< (OSHP-1);

   // global advance, stalls only while the skid entry is full
   logic en;
   logic skid_v_ff;
   assign en         = !skid_v_ff;
   assign req_tready = !skid_v_ff;

   // request fields
   logic signed [VB-1:0] req_q;
   logic signed [VB-1:0] req_d;
   logic [ANGLE_BITS-1:0] req_angle;
   logic [31:0] zl;
   logic        flip;
   assign req_q     = req_tdata[VB-1:0];
   assign req_d     = req_tdata[2*VB-1:VB];
   assign req_angle = req_tdata[2*VB+ANGLE_BITS-1:2*VB];
   // angle left-aligned to a 32-bit turn; quadrants two and three folded by half a turn
   assign zl   = 32'(req_angle) << (32 - ANGLE_BITS);
   assign flip = zl[31] ^ zl[30];

   // cordic pipeline, index 0 is the input register
   logic                 cv_ff   [NS+1];
   logic signed [31:0]   cx_ff   [NS+1];
   logic signed [31:0]   cy_ff   [NS+1];
   logic signed [31:0]   cz_ff   [NS+1];
   logic signed [VB-1:0] cq_ff   [NS+1];
   logic signed [VB-1:0] cd_ff   [NS+1];
   logic                 cf_ff   [NS+1];

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0] <= TRIG_ONE_GAIN;
         cy_ff[0] <= '0;
         cz_ff[0] <= {zl[31] ^ flip, zl[30:0]};
         cq_ff[0] <= req_q;
         cd_ff[0] <= req_d;
         cf_ff[0] <= flip;
      end
   end

   // one rotation per stage
   for (genvar k = 1; k <= NS; k++) begin : g_cordic
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] da;
      assign dx = cy_ff[k-1] >>> (k-1);
      assign dy = cx_ff[k-1] >>> (k-1);
      assign da = $signed(ATAN_TURN[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k] <= 1'b0;
         end else if (en) begin
            cv_ff[k] <= cv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!cz_ff[k-1][31]) begin
               cx_ff[k] <= cx_ff[k-1] - dx;
               cy_ff[k] <= cy_ff[k-1] + dy;
               cz_ff[k] <= cz_ff[k-1] - da;
            end else begin
               cx_ff[k] <= cx_ff[k-1] + dx;
               cy_ff[k] <= cy_ff[k-1] - dy;
               cz_ff[k] <= cz_ff[k-1] + da;
            end
            cq_ff[k] <= cq_ff[k-1];
            cd_ff[k] <= cd_ff[k-1];
            cf_ff[k] <= cf_ff[k-1];
         end
      end
   end

   // datapath registers after the cordic
   logic                  sc_v_ff, mu_v_ff, ab_v_ff, hp_v_ff, hn_v_ff;
   logic                  ph_v_ff, mm_v_ff, nt_v_ff, df_v_ff, ro_v_ff;
   logic signed [31:0]    s_ff, c_ff;
   logic signed [VB-1:0]  sq_ff, sd_ff;
   logic signed [PW-1:0]  p_sq_ff, p_cd_ff, p_cq_ff, p_sd_ff;
   logic signed [AW-1:0]  alpha_ff, beta_ff, hp_alpha_ff;
   logic signed [63:0]    hprod_ff;
   logic signed [PHW-1:0] hb_ff, nah_ff, hn_alpha_ff;
   logic signed [PHW-1:0] pa_ff, pb_ff, pc_ff;
   logic signed [PHW-1:0] mx_ff, mn_ff, ma_ff, mb_ff, mc_ff;
   logic signed [PHW-1:0] n_ff, na_ff, nb_ff, nc_ff;
   logic signed [PHW-1:0] da_ff, db_ff, dc_ff;
   logic [OW-1:0]         oa_ff, ob_ff, oc_ff;

   // next values that need more than one line
   logic signed [SW-1:0]  alpha_sum, beta_sum;
   logic signed [PHW-1:0] mx_in, mn_in, n_sum;

   // round Q30 to the output format and keep the field width
   function automatic logic [OW-1:0] to_out(input logic signed [PHW-1:0] v);
      logic signed [TW-1:0] t;
      begin
         t = TW'(v);
         if (OSH > 0) begin
            t = (t + RND_O) >>> OSHP;
         end else if (OSH < 0) begin
            t = t <<< 1;
         end
         return OW'(t);
      end
   endfunction

   // rounded alpha and beta sums
   always_comb begin
      alpha_sum = SW'(p_cd_ff) - SW'(p_sq_ff) + RND_V;
      beta_sum  = SW'(p_cq_ff) + SW'(p_sd_ff) + RND_V;
   end

   // largest and smallest phase, then the neutral
   always_comb begin
      mx_in = pa_ff;
      mn_in = pa_ff;
      if (pb_ff > mx_in) mx_in = pb_ff;
      if (pc_ff > mx_in) mx_in = pc_ff;
      if (pb_ff < mn_in) mn_in = pb_ff;
      if (pc_ff < mn_in) mn_in = pc_ff;
      n_sum = (mx_ff + mn_ff) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff <= 1'b0;
         mu_v_ff <= 1'b0;
         ab_v_ff <= 1'b0;
         hp_v_ff <= 1'b0;
         hn_v_ff <= 1'b0;
         ph_v_ff <= 1'b0;
         mm_v_ff <= 1'b0;
         nt_v_ff <= 1'b0;
         df_v_ff <= 1'b0;
         ro_v_ff <= 1'b0;
      end else if (en) begin
         sc_v_ff <= cv_ff[NS];
         mu_v_ff <= sc_v_ff;
         ab_v_ff <= mu_v_ff;
         hp_v_ff <= ab_v_ff;
         hn_v_ff <= hp_v_ff;
         ph_v_ff <= hn_v_ff;
         mm_v_ff <= ph_v_ff;
         nt_v_ff <= mm_v_ff;
         df_v_ff <= nt_v_ff;
         ro_v_ff <= df_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // undo the half-turn fold
         s_ff  <= cf_ff[NS] ? -cy_ff[NS] : cy_ff[NS];
         c_ff  <= cf_ff[NS] ? -cx_ff[NS] : cx_ff[NS];
         sq_ff <= cq_ff[NS];
         sd_ff <= cd_ff[NS];
         // inverse park products
         p_sq_ff <= PW'(s_ff) * PW'(sq_ff);
         p_cd_ff <= PW'(c_ff) * PW'(sd_ff);
         p_cq_ff <= PW'(c_ff) * PW'(sq_ff);
         p_sd_ff <= PW'(s_ff) * PW'(sd_ff);
         // alpha and beta in Q30
         alpha_ff <= AW'(alpha_sum >>> (VB-1));
         beta_ff  <= AW'(beta_sum >>> (VB-1));
         // beta scaled by sqrt3/2
         hprod_ff    <= 64'(beta_ff) * 64'(HALF_SQRT3_Q30);
         hp_alpha_ff <= alpha_ff;
         hb_ff       <= PHW'((hprod_ff + HALF_Q30_RND) >>> 30);
         nah_ff      <= (-PHW'(hp_alpha_ff)) >>> 1;
         hn_alpha_ff <= PHW'(hp_alpha_ff);
         // inverse clarke
         pa_ff <= hn_alpha_ff;
         pb_ff <= nah_ff + hb_ff;
         pc_ff <= nah_ff - hb_ff;
         // min-max injection
         mx_ff <= mx_in;
         mn_ff <= mn_in;
         ma_ff <= pa_ff;
         mb_ff <= pb_ff;
         mc_ff <= pc_ff;
         n_ff  <= n_sum;
         na_ff <= ma_ff;
         nb_ff <= mb_ff;
         nc_ff <= mc_ff;
         da_ff <= na_ff - n_ff;
         db_ff <= nb_ff - n_ff;
         dc_ff <= nc_ff - n_ff;
         // output format
         oa_ff <= to_out(da_ff);
         ob_ff <= to_out(db_ff);
         oc_ff <= to_out(dc_ff);
      end
   end

   // output register and skid entry
   logic [3*OW-1:0] tail_d;
   logic [3*OW-1:0] out_d_ff, skid_d_ff;
   logic            out_v_ff;
   logic            out_free;
   assign tail_d   = {oc_ff, ob_ff, oa_ff};
   assign out_free = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || (en && ro_v_ff);
         skid_v_ff <= 1'b0;
      end else if (en && ro_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_d_ff <= skid_v_ff ? skid_d_ff : tail_d;
      end else if (en && ro_v_ff) begin
         skid_d_ff <= tail_d;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_W'(out_d_ff);

`ifndef NO_ASSERTIONS
   // the skid entry only holds a result behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry full while output register empty");

   // the skid entry fills only when the output was stalled
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid entry filled without an output stall");

   // the pipeline tail holds while the skid entry is full
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(ro_v_ff) && $stable(tail_d))
      else $error("pipeline moved while stalled");

   // folded angle residue lies within a quarter turn of zero
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      cv_ff[0] |-> (cz_ff[0][31] == cz_ff[0][30]))
      else $error("angle residue outside the folded range");
`endif

endmodule

FILE: tb/ipsv_checker.sv
// Scoreboard for inverse_park_svpwm: watches the request and result channels, predicts
// the three phase voltages of every accepted request and compares them in order.
// Stand-alone; needs nothing but the channel signals of the block.
module ipsv_checker #(
   parameter int VOLTAGE_BITS  = 16,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16,
   parameter int REQ_W         = 48,
   parameter int RSP_W         = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // fields from bit 0: q_voltage, d_voltage, angle
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // fields from bit 0: phase_a, phase_b, phase_c, zero fill
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               outstanding,
   output int               checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB = VOLTAGE_BITS;
   localparam int AB = ANGLE_BITS;
   localparam int OW = VOLTAGE_BITS + 2;

   // start value of x (reciprocal CORDIC gain) and sqrt(3)/2, both Q1.30
   localparam longint TRIG_GAIN_Q30 = 652032874;
   localparam longint SQRT3_HALF_Q30 = 929887697;

   // arctangent of 2^-i, 2^32 units per turn
   localparam logic [31:0] ARCTAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   typedef struct packed {
      logic [OW-1:0] c;
      logic [OW-1:0] b;
      logic [OW-1:0] a;
   } phase_set_type;

   phase_set_type expected_phases [$];
   int failures = 0;
   int pending_now = 0;
   int results_seen = 0;

   assign fail_count    = failures;
   assign outstanding   = pending_now;
   assign checked_count = results_seen;

   // add half an LSB, then floor shift
   function automatic longint round_down_shift(input longint v, input int s);
      if (s <= 0)
         return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // Q30 phase value to the output format, masked to the field width
   function automatic logic [OW-1:0] to_phase_bits(input longint q30);
      longint v;
      if (31 - VB >= 0)
         v = round_down_shift(q30, 31 - VB);
      else
         v = q30 * 2;
      return v[OW-1:0];
   endfunction

   function automatic phase_set_type predict_phases(input logic signed [VB-1:0] q_in,
                                                    input logic signed [VB-1:0] d_in,
                                                    input logic [AB-1:0] ang);
      logic [31:0]   turn;
      logic          mirrored;
      longint        z, x, y, dx, dy, vq, vd, alpha, beta, hb, pa, pb, pc, hi, lo, neutral;
      int            i;
      phase_set_type p;
      // angle left-aligned to a 32-bit turn; second and third quadrants turned by pi
      turn = 32'(ang) << (32 - AB);
      mirrored = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
      if (mirrored)
         turn = turn - 32'h8000_0000;
      z = longint'($signed(turn));
      x = TRIG_GAIN_Q30;
      y = 0;
      // rotation-mode cordic
      for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ARCTAN_TURN[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ARCTAN_TURN[i]);
         end
      end
      if (mirrored) begin
         x = -x;
         y = -y;
      end
      // inverse park: x is cosine, y is sine
      vq = q_in;
      vd = d_in;
      alpha = round_down_shift(-(y * vq) + (x * vd), VB - 1);
      beta  = round_down_shift((x * vq) + (y * vd), VB - 1);
      // inverse clarke
      hb = round_down_shift(beta * SQRT3_HALF_Q30, 30);
      pa = alpha;
      pb = ((-alpha) >>> 1) + hb;
      pc = ((-alpha) >>> 1) - hb;
      // min-max zero-sequence removal
      hi = pa;
      lo = pa;
      if (pb > hi) hi = pb;
      if (pc > hi) hi = pc;
      if (pb < lo) lo = pb;
      if (pc < lo) lo = pc;
      neutral = (hi + lo) >>> 1;
      p.a = to_phase_bits(pa - neutral);
      p.b = to_phase_bits(pb - neutral);
      p.c = to_phase_bits(pc - neutral);
      return p;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10)
         $display("%0t mismatch: %s", $realtime, msg);
   endfunction

   // predict on every accepted request, compare every accepted result
   always @(posedge clock) begin
      phase_set_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[3*OW-1:0];
            results_seen++;
            if (expected_phases.size() == 0) begin
               note_failure($sformatf("result with no request pending, data %h", rsp_tdata));
            end else begin
               want = expected_phases.pop_front();
               if (got.a !== want.a || got.b !== want.b || got.c !== want.c)
                  note_failure($sformatf(
                     "result %0d expected a=%0d b=%0d c=%0d got a=%0d b=%0d c=%0d",
                     results_seen, $signed(want.a), $signed(want.b), $signed(want.c),
                     $signed(got.a), $signed(got.b), $signed(got.c)));
            end
         end
         if (req_tvalid && req_tready)
            expected_phases.push_back(predict_phases(req_tdata[VB-1:0],
                                                     req_tdata[2*VB-1:VB],
                                                     req_tdata[2*VB+AB-1:2*VB]));
      end
      pending_now = expected_phases.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the inverse_park_svpwm testbench: clock, reset, request and result stimulus
// with random idling and one long output stall, and the verdict.
// Depends on inverse_park_svpwm and ipsv_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB            = 16;
   localparam int AB            = 16;
   localparam int STAGES        = 16;
   localparam int REQ_W         = ((2*VB+AB+7)/8)*8;
   localparam int RSP_W         = ((3*(VB+2)+7)/8)*8;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = STAGES + 12 + 8;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // fields from bit 0: q_voltage, d_voltage, angle
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // fields from bit 0: phase_a, phase_b, phase_c, zero fill
   logic [RSP_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int checked_count;
   int requests_sent = 0;
   bit steady_flow = 1'b0;
   bit hold_off_pending = 1'b0;

   always #5 clock = ~clock;

   inverse_park_svpwm #(
      .VOLTAGE_BITS (VB),
      .ANGLE_BITS   (AB),
      .CORDIC_STAGES(STAGES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   ipsv_checker #(
      .VOLTAGE_BITS (VB),
      .ANGLE_BITS   (AB),
      .CORDIC_STAGES(STAGES),
      .REQ_W        (REQ_W),
      .RSP_W        (RSP_W)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .checked_count(checked_count)
   );

   // offer one request, with random idle cycles in front of it
   task automatic send_request(input logic [VB-1:0] q, input logic [VB-1:0] d,
                               input logic [AB-1:0] ang);
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'({$urandom, $urandom});
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({ang, d, q});
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // mostly uniform voltages, sometimes one of the corner values around zero and full scale
   function automatic logic [VB-1:0] pick_voltage();
      logic [VB-1:0] corners [7] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
                                     16'h0001, 16'h7FFE, 16'h7FFF};
      if ($urandom_range(9) < 2)
         return corners[$urandom_range(6)];
      return VB'($urandom);
   endfunction

   // result side: random back-pressure, plus one long hold-off on request
   initial begin : result_side
      int held;
      forever begin
         @(posedge clock);
         if (hold_off_pending && !reset) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(99) >= 36);
         end
      end
   end

   initial begin : stimulus
      int n;
      logic [VB-1:0] q, d;
      logic [AB-1:0] ang;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // quadrant boundaries and their neighbors
      send_request(16'h7FFF, 16'h0000, 16'h0000);
      send_request(16'h7FFF, 16'h0000, 16'h3FFF);
      send_request(16'h7FFF, 16'h0000, 16'h4000);
      send_request(16'h7FFF, 16'h0000, 16'h4001);
      send_request(16'h0000, 16'h7FFF, 16'h7FFF);
      send_request(16'h0000, 16'h7FFF, 16'h8000);
      send_request(16'h0000, 16'h8000, 16'hBFFF);
      send_request(16'h8000, 16'h0000, 16'hC000);
      send_request(16'h8000, 16'h8000, 16'hFFFF);
      // largest magnitudes: both commands at full scale, at 15, 30, 45, 135 and 315 degrees
      send_request(16'h7FFF, 16'h7FFF, 16'h1555);
      send_request(16'h8000, 16'h8000, 16'h0AAB);
      send_request(16'h7FFF, 16'h8000, 16'h2000);
      send_request(16'h8000, 16'h7FFF, 16'h6000);
      send_request(16'h8000, 16'h8000, 16'hE000);
      // zero and smallest commands
      send_request(16'h0000, 16'h0000, 16'h1234);
      send_request(16'h0001, 16'hFFFF, 16'hA000);
      send_request(16'hFFFF, 16'h0001, 16'h5555);
      // angle equal to the q command
      send_request(16'h8000, 16'h0000, 16'h8000);
      send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_request(16'hC000, 16'h4000, 16'hC000);

      // random commands; a calm stretch, then a long output stall mid-run
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady_flow = (n >= 200 && n < 500);
         if (n == 1000)
            hold_off_pending = 1'b1;
         q = pick_voltage();
         d = pick_voltage();
         case ($urandom_range(9))
            0, 1: ang = AB'(q);
            2: ang = (AB'($urandom_range(3)) << (AB - 2)) + AB'($urandom_range(4)) - AB'(2);
            default: ang = AB'($urandom);
         endcase
         send_request(q, d, ang);
      end
      req_tvalid <= 1'b0;
      steady_flow = 1'b0;

      // drain, then allow the pipeline depth for stray results
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests: quadrant edges, full-scale corners, random commands",
               requests_sent);
      $display("checked %0d phase triples under idling and a %0d-cycle output stall",
               checked_count, HOLD_CYCLES);
      if (fail_count == 0)
         $display("PASS inverse_park_svpwm");
      else
         $display("FAIL inverse_park_svpwm");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d results outstanding", outstanding);
      $display("FAIL inverse_park_svpwm");
      $finish;
   end

endmodule
